// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked out of reset only
`define BIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BIS_ASSERT(lbl, prop, msg)
`define BIS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Types, codes and helper functions shared by the bitmap integer set.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int IDX_W      = 8;   // element index width
  localparam int CNT_W      = 9;   // member count width
  localparam int KIND_W     = 3;
  localparam int WORD_W     = 16;  // bitmap word, one read per cycle
  localparam int WORD_SHIFT = 4;   // log2(WORD_W)
  localparam int POP_W      = 5;   // popcount of one word

  localparam logic [IDX_W-1:0] TOP_RESET = 8'hFF;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEGATE = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
  } bis_in_t;

  typedef struct packed {
    logic             range_error;
    logic             is_member;
    logic             has_next;
    logic [IDX_W-1:0] next_index;
    logic [CNT_W-1:0] member_count;
    logic             has_first;
    logic [IDX_W-1:0] first_index;
  } bis_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_SWEEP,
    ST_LOOKUP,
    ST_SCAN,
    ST_REPORT
  } bis_state_t;

  // datapath command
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MODIFY,
    OP_SWEEP,
    OP_LOOKUP,
    OP_SCAN,
    OP_FINISH
  } bis_op_t;

  // class of the item on the input bus
  typedef enum logic [1:0] {
    CLS_QUERY,
    CLS_MODIFY,
    CLS_SWEEP,
    CLS_ERROR
  } bis_cls_t;

  typedef struct packed {
    bis_cls_t in_cls;     // class of the item being offered
    logic     rm_least;   // remove hits the least member: rescan needed
    logic     sweep_last; // sweep pointer on the last word
    logic     need_scan;  // successor not in the index word, more words to walk
    logic     scan_done;  // successor found or top word reached
  } bis_status_t;

  function automatic logic [POP_W-1:0] popcnt16(input logic [WORD_W-1:0] w);
    logic [2:0] nib [4];
    for (int q = 0; q < 4; q++) begin
      nib[q] = 3'(w[4*q]) + 3'(w[4*q+1]) + 3'(w[4*q+2]) + 3'(w[4*q+3]);
    end
    return POP_W'(nib[0]) + POP_W'(nib[1]) + POP_W'(nib[2]) + POP_W'(nib[3]);
  endfunction

  // position of the lowest set bit, 0 when none
  function automatic logic [WORD_SHIFT-1:0] ffs16(input logic [WORD_W-1:0] w);
    logic [WORD_SHIFT-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = WORD_SHIFT'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/bis_ctrl.sv =====
// ----------------------------------------------------------------------------
// bis_ctrl
// Sequencer: steps the datapath through modify, sweep, lookup and scan.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bis_pkg::bis_status_t status,
  output bis_pkg::bis_op_t     op
);
  import bis_pkg::*;

  bis_state_t state_r;
  bis_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (status.in_cls)
            CLS_SWEEP:  state_nxt = ST_SWEEP;
            CLS_ERROR:  state_nxt = ST_REPORT;
            CLS_MODIFY: state_nxt = ST_MODIFY;
            CLS_QUERY:  state_nxt = ST_LOOKUP;
            default:    state_nxt = ST_LOOKUP;
          endcase
        end
      end
      ST_MODIFY: begin
        state_nxt = status.rm_least ? ST_SWEEP : ST_LOOKUP;
      end
      ST_SWEEP: begin
        if (status.sweep_last) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = status.need_scan ? ST_SCAN : ST_REPORT;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = 1'b1;
    op   = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        op   = start ? OP_LOAD : OP_NONE;
      end
      ST_MODIFY: op = OP_MODIFY;
      ST_SWEEP:  op = OP_SWEEP;
      ST_LOOKUP: op = OP_LOOKUP;
      ST_SCAN:   op = OP_SCAN;
      ST_REPORT: op = OP_FINISH;
      default:   op = OP_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/bis_dp.sv =====
// ----------------------------------------------------------------------------
// bis_dp
// Bitmap words, member count, least member, successor walk, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bis_dp #(
  parameter int UNIVERSE_SIZE = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bis_pkg::bis_op_t                op,
  output bis_pkg::bis_status_t            status,
  input  bis_pkg::bis_in_t                in_data,
  input  logic                            cfg_we,
  input  logic [bis_pkg::IDX_W-1:0]       cfg_data,
  output logic                            out_valid,
  output bis_pkg::bis_out_t               out_data
);
  import bis_pkg::*;

  // only the first 256 elements are reachable through an 8-bit index
  localparam int STORE  = (UNIVERSE_SIZE < (1 << IDX_W)) ? UNIVERSE_SIZE : (1 << IDX_W);
  localparam int WORDS  = (STORE + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NWORDS = 1 << WIDX_W;
  localparam logic [IDX_W-1:0]  LAST_ELEM = IDX_W'(STORE - 1);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);

  logic [WORD_W-1:0] words_r [NWORDS];

  logic [IDX_W-1:0]  top_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  least_r;
  logic              least_valid_r;
  logic [WIDX_W-1:0] ptr_r;
  logic [CNT_W-1:0]  acc_cnt_r;
  logic              acc_found_r;
  logic [IDX_W-1:0]  acc_first_r;
  logic              out_valid_r;
  bis_out_t          out_r;

  logic [KIND_W-1:0] kind_r;
  logic [IDX_W-1:0]  idx_r;
  logic              err_r;
  logic              member_r;
  logic              has_next_r;
  logic [IDX_W-1:0]  next_r;

  logic [IDX_W-1:0]  eff_top;
  logic [WIDX_W-1:0] top_word;
  logic [WIDX_W-1:0] idx_word;
  logic [WIDX_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] le_top;
  logic [WORD_W-1:0] gt_idx;
  logic [WORD_W-1:0] onehot;
  logic [WORD_W-1:0] cand;
  logic              cand_hit;
  logic [IDX_W-1:0]  cand_idx;
  logic              bit_set;
  logic              idx_in_rng;
  logic              live_in_rng;
  logic [WORD_W-1:0] mod_word;
  logic [WORD_W-1:0] sweep_word;
  logic              sweep_hit;
  logic [IDX_W-1:0]  sweep_first;
  logic [CNT_W-1:0]  acc_cnt_sum;

  assign eff_top  = (top_r > LAST_ELEM) ? LAST_ELEM : top_r;
  assign top_word = eff_top[WORD_SHIFT +: WIDX_W];
  assign idx_word = idx_r[WORD_SHIFT +: WIDX_W];

  // single read port: index word for modify/lookup, pointer otherwise
  assign rd_addr = ((op == OP_MODIFY) || (op == OP_LOOKUP)) ? idx_word : ptr_r;
  assign rd_word = words_r[rd_addr];

  // per-bit element masks for the word being read
  always_comb begin
    logic [IDX_W-1:0] elem;
    elem = '0;
    for (int b = 0; b < WORD_W; b++) begin
      elem      = IDX_W'({rd_addr, WORD_SHIFT'(b)});
      le_top[b] = (elem <= eff_top);
      gt_idx[b] = (elem > idx_r);
    end
  end

  assign onehot      = WORD_W'(1) << idx_r[WORD_SHIFT-1:0];
  assign bit_set     = rd_word[idx_r[WORD_SHIFT-1:0]];
  assign idx_in_rng  = (idx_r <= eff_top);
  assign live_in_rng = (in_data.index <= eff_top);

  assign cand     = rd_word & le_top & gt_idx;
  assign cand_hit = |cand;
  assign cand_idx = IDX_W'({rd_addr, ffs16(cand)});

  assign mod_word = (kind_r == KIND_INSERT) ? (rd_word | onehot) : (rd_word & ~onehot);

  always_comb begin
    priority if (kind_r == KIND_CLEAR) begin
      sweep_word = '0;
    end else if (kind_r == KIND_NEGATE) begin
      sweep_word = rd_word ^ le_top;
    end else begin
      sweep_word = rd_word;  // rescan only
    end
  end

  assign sweep_hit   = |sweep_word;
  assign sweep_first = IDX_W'({ptr_r, ffs16(sweep_word)});
  assign acc_cnt_sum = acc_cnt_r + CNT_W'(popcnt16(sweep_word));

  // status to the sequencer
  always_comb begin
    priority if ((in_data.kind == KIND_CLEAR) || (in_data.kind == KIND_NEGATE)) begin
      status.in_cls = CLS_SWEEP;
    end else if (!live_in_rng) begin
      status.in_cls = CLS_ERROR;
    end else if ((in_data.kind == KIND_INSERT) || (in_data.kind == KIND_REMOVE)) begin
      status.in_cls = CLS_MODIFY;
    end else begin
      status.in_cls = CLS_QUERY;
    end
    status.rm_least   = (kind_r == KIND_REMOVE) && bit_set && least_valid_r &&
                        (least_r == idx_r);
    status.sweep_last = (ptr_r == LAST_WORD);
    status.need_scan  = idx_in_rng && bit_set && !cand_hit && (idx_word != top_word);
    status.scan_done  = cand_hit || (ptr_r == top_word);
  end

  // bitmap words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NWORDS; w++) begin
        words_r[w] <= '0;
      end
    end else begin
      unique case (op)
        OP_MODIFY: words_r[idx_word] <= mod_word;
        OP_SWEEP:  words_r[ptr_r]    <= sweep_word;
        default: ;
      endcase
    end
  end

  // control and summary state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r         <= TOP_RESET;
      count_r       <= '0;
      least_r       <= '0;
      least_valid_r <= 1'b0;
      ptr_r         <= '0;
      acc_cnt_r     <= '0;
      acc_found_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= (op == OP_FINISH);
      if (cfg_we) begin
        top_r <= cfg_data;
      end
      unique case (op)
        OP_LOAD: begin
          ptr_r       <= '0;
          acc_cnt_r   <= '0;
          acc_found_r <= 1'b0;
        end
        OP_MODIFY: begin
          if (kind_r == KIND_INSERT) begin
            if (!bit_set) begin
              count_r <= count_r + CNT_W'(1);
            end
            if (!least_valid_r || (idx_r < least_r)) begin
              least_r       <= idx_r;
              least_valid_r <= 1'b1;
            end
          end else if (bit_set) begin
            count_r <= count_r - CNT_W'(1);
          end
        end
        OP_SWEEP: begin
          ptr_r     <= ptr_r + WIDX_W'(1);
          acc_cnt_r <= acc_cnt_sum;
          if (!acc_found_r && sweep_hit) begin
            acc_found_r <= 1'b1;
          end
          if (status.sweep_last) begin
            count_r       <= acc_cnt_sum;
            least_valid_r <= acc_found_r || sweep_hit;
            least_r       <= acc_found_r ? acc_first_r : (sweep_hit ? sweep_first : '0);
          end
        end
        OP_LOOKUP: ptr_r <= idx_word + WIDX_W'(1);
        OP_SCAN:   ptr_r <= ptr_r + WIDX_W'(1);
        default: ;
      endcase
    end
  end

  // item payload and result
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        kind_r     <= in_data.kind;
        idx_r      <= in_data.index;
        err_r      <= (status.in_cls == CLS_ERROR);
        member_r   <= 1'b0;
        has_next_r <= 1'b0;
        next_r     <= '0;
      end
      OP_SWEEP: begin
        if (!acc_found_r && sweep_hit) begin
          acc_first_r <= sweep_first;
        end
      end
      OP_LOOKUP: begin
        member_r   <= idx_in_rng && bit_set;
        has_next_r <= idx_in_rng && bit_set && cand_hit;
        next_r     <= (idx_in_rng && bit_set && cand_hit) ? cand_idx : '0;
      end
      OP_SCAN: begin
        if (cand_hit) begin
          has_next_r <= 1'b1;
          next_r     <= cand_idx;
        end
      end
      OP_FINISH: begin
        out_r.range_error  <= err_r;
        out_r.is_member    <= member_r;
        out_r.has_next     <= has_next_r;
        out_r.next_index   <= next_r;
        out_r.member_count <= count_r;
        out_r.has_first    <= least_valid_r;
        out_r.first_index  <= least_valid_r ? least_r : '0;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BIS_ASSERT(a_strobe_single, out_valid_r |=> !out_valid_r, "result strobe held over two cycles")
  `BIS_ASSERT(a_count_bound, count_r <= CNT_W'(STORE), "member count above store size")
  `BIS_ASSERT(a_first_tracks_count, (op == OP_FINISH) |-> (least_valid_r == (count_r != '0)), "least member flag disagrees with count")
  `BIS_ASSERT(a_next_above_index, (op == OP_FINISH) && has_next_r |-> member_r && (next_r > idx_r), "successor not above a member index")
  `BIS_ASSERT(a_error_quiet, (op == OP_FINISH) && err_r |-> !member_r && !has_next_r, "range error reported with membership")

endmodule

// ===== hw/rtl/bitmap_integer_set.sv =====
// ----------------------------------------------------------------------------
// bitmap_integer_set
// Sequence: a query runs lookup then report, insert/remove run modify, lookup, report,
//   a range error goes straight to report; a successor walk scans further 16-bit words.
// Clear, negate and removal of the least member add a sweep over every word
//   (16 at 256 elements). Next item accepted in the cycle the strobe is shown.
// Reset: synchronous; empties the set and sets top_element to 255 at once.
// ----------------------------------------------------------------------------
module bitmap_integer_set #(
  parameter int UNIVERSE_SIZE = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel: transaction taken when start is high and busy is low
  input  logic                      start,
  output logic                      busy,
  input  bis_pkg::bis_in_t          in_data,
  // result channel: one-cycle strobe, receiver cannot stall
  output logic                      out_valid,
  output bis_pkg::bis_out_t         out_data,
  // top_element register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bis_pkg::IDX_W-1:0] cfg_data
);
  import bis_pkg::*;

  bis_op_t     op;
  bis_status_t status;
  logic        cfg_we;

  // the register is only written between transactions, never in the cycle
  // a command is being taken
  assign cfg_ready = ~busy & ~start;
  assign cfg_we    = cfg_valid & cfg_ready;

  // sequencer: one state per phase of an operation
  bis_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .op     (op)
  );

  // bitmap store, summary registers and the result register
  bis_dp #(
    .UNIVERSE_SIZE (UNIVERSE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb_bitmap_integer_set.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_integer_set
// Self-checking bench for the bitmap integer set: a behavioral copy of the
// set predicts every report, a monitor compares each strobed result field by
// field, and named tests cover reset state, each operation, top changes and
// long random runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bitmap_integer_set;
  import bis_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int WATCHDOG_LIMIT = 4000;  // well above the worst item
  localparam int SETTLE_CYCLES  = 60;    // a negate plus a full successor walk

  // kinds 5..7 are unused and behave as a query
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_NEGATE + 1'b1;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  bis_in_t          in_data;
  logic             out_valid;
  bis_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_data;

  bitmap_integer_set dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the set. Count and least member are recomputed from the
  // bitmap each time; that matches the incremental bookkeeping in the block,
  // including members stranded above a lowered top.
  // --------------------------------------------------------------------------
  logic [255:0]     shadow_bits;
  int               top_limit;
  bis_out_t         pending_reports[$];
  int               fail_count;
  int               gap_pct;       // chance in percent of a sender gap
  int               idle_cycles;

  function automatic bis_out_t apply_set_op(input bis_in_t item);
    bis_out_t rep;
    int       idx;
    logic     in_range;
    logic     sweep_kind;
    rep        = '0;
    idx        = int'(item.index);
    in_range   = (idx <= top_limit);
    sweep_kind = (item.kind == KIND_CLEAR) || (item.kind == KIND_NEGATE);

    case (item.kind)
      KIND_CLEAR: begin
        shadow_bits = '0;              // whole store, above the top too
      end
      KIND_NEGATE: begin
        for (int j = 0; j <= top_limit; j++) shadow_bits[j] = ~shadow_bits[j];
      end
      KIND_INSERT: begin
        if (in_range) shadow_bits[idx] = 1'b1;
      end
      KIND_REMOVE: begin
        if (in_range) shadow_bits[idx] = 1'b0;
      end
      default: ;                       // query and the unused kinds
    endcase

    rep.range_error = !in_range && !sweep_kind;
    if (in_range) begin
      rep.is_member = shadow_bits[idx];
      // successor walk stops at the top, not at the end of the store
      if (rep.is_member && idx < top_limit) begin
        for (int j = idx + 1; j <= top_limit; j++) begin
          if (shadow_bits[j] && !rep.has_next) begin
            rep.has_next   = 1'b1;
            rep.next_index = IDX_W'(j);
          end
        end
      end
    end

    for (int j = 0; j < 256; j++) begin
      if (shadow_bits[j]) begin
        if (!rep.has_first) begin
          rep.has_first   = 1'b1;
          rep.first_index = IDX_W'(j);
        end
        rep.member_count = rep.member_count + CNT_W'(1);
      end
    end
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result monitor: the receiver cannot stall, so every strobe is a
  // transaction and is matched against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    bis_out_t exp_rep;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        fail_count++;
      end else begin
        exp_rep = pending_reports.pop_front();
        check_field("range_error",  32'(exp_rep.range_error),  32'(out_data.range_error));
        check_field("is_member",    32'(exp_rep.is_member),    32'(out_data.is_member));
        check_field("has_next",     32'(exp_rep.has_next),     32'(out_data.has_next));
        check_field("next_index",   32'(exp_rep.next_index),   32'(out_data.next_index));
        check_field("member_count", 32'(exp_rep.member_count), 32'(out_data.member_count));
        check_field("has_first",    32'(exp_rep.has_first),    32'(out_data.has_first));
        check_field("first_index",  32'(exp_rep.first_index),  32'(out_data.first_index));
      end
    end
  end

  // watchdog: any accepted transaction on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Everything is driven at the falling edge; acceptance is
  // judged at the rising edge from the pre-edge value of busy.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] index);
    bis_in_t item;
    item.kind  = kind;
    item.index = index;
    @(negedge clk);
    if ($urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    pending_reports.push_back(apply_set_op(item));
  endtask

  // drop start and hold off until every report has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // the register is only written with the block idle
  task automatic write_top(input logic [IDX_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    top_limit = int'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // set must come out of reset empty with the top at its reset value
  task automatic test_empty_set();
    send_item(KIND_QUERY, 8'd0);
    send_item(KIND_QUERY, 8'd255);
  endtask

  // insert, remove, query and the unused kinds, successor across the extremes, least-member removal
  task automatic test_basic_ops();
    send_item(KIND_INSERT, 8'd255);
    send_item(KIND_INSERT, 8'd0);
    send_item(KIND_QUERY,  8'd0);     // successor at the far end
    send_item(KIND_INSERT, 8'd128);
    send_item(KIND_QUERY,  8'd0);
    send_item(KIND_INSERT, 8'd128);   // duplicate insert, count unchanged
    send_item(KIND_REMOVE, 8'd0);     // least member goes: rescan
    send_item(KIND_QUERY,  8'd128);
    send_item(KIND_QUERY,  8'd255);   // member at the top has no successor
    send_item(KIND_REMOVE, 8'd77);    // non-member
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
      send_item(KIND_W'(k), 8'd128);
    end
  endtask

  // whole-store sweeps with the full range in use
  task automatic test_sweeps();
    send_item(KIND_NEGATE, 8'd128);
    send_item(KIND_CLEAR,  8'd255);
  endtask

  // lowered top: stranded members, out-of-range indexes, sweeps above top
  task automatic test_top_limits();
    send_item(KIND_INSERT, 8'd200);
    write_top(8'd0);                  // no clear: 200 stays in the store
    send_item(KIND_QUERY,  8'd200);   // range error, count still 1
    send_item(KIND_INSERT, 8'd0);
    send_item(KIND_NEGATE, 8'd0);     // flips only entry 0
    send_item(KIND_CLEAR,  8'd200);   // above top, yet no range error
  endtask

  // one random run at a given top; mostly in-range traffic to build up state
  task automatic run_random_phase(input int top, input bit clear_first, input int n_items);
    int                r;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    write_top(IDX_W'(top));
    if (clear_first) send_item(KIND_CLEAR, IDX_W'($urandom_range(0, 255)));
    for (int i = 0; i < n_items; i++) begin
      if ((i == n_items / 2) && (gap_pct != 0)) begin
        wait_drained();               // pause until all reports are back
        gap_pct = $urandom_range(0, 1) ? 0 : 30;
      end
      r = $urandom_range(0, 99);
      if (r < 3)       kind = KIND_CLEAR;
      else if (r < 7)  kind = KIND_NEGATE;
      else if (r < 11) kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if (r < 48) kind = KIND_INSERT;
      else if (r < 72) kind = KIND_REMOVE;
      else             kind = KIND_QUERY;
      if (kind == KIND_CLEAR || kind == KIND_NEGATE || (top < 255 && $urandom_range(0, 9) == 0))
        index = IDX_W'($urandom_range(0, 255));
      else
        index = IDX_W'($urandom_range(0, top));
      send_item(kind, index);
    end
  endtask

  task automatic test_random_tops();
    gap_pct = 30;
    run_random_phase(255, 1'b1, 150);
    run_random_phase(17, 1'b1, 140);
    run_random_phase(0, 1'b1, 40);
    run_random_phase($urandom_range(2, 254), 1'b0, 140);   // stranded members
    run_random_phase(1, 1'b1, 60);
    run_random_phase($urandom_range(2, 254), 1'b1, 140);
    run_random_phase(255, 1'b0, 140);
  endtask

  // closing stretch with the sender never idle
  task automatic test_back_to_back();
    gap_pct = 0;
    run_random_phase(255, 1'b1, 160);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    shadow_bits = '0;
    top_limit   = int'(TOP_RESET);
    gap_pct     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_set();
    test_basic_ops();
    test_sweeps();
    test_top_limits();
    test_random_tops();
    test_back_to_back();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
